[rtl/lcdne_pkg.sv]
package lcdne_pkg;

    // request codes on the command field
    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_LOCATE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_WRITE  = 2'd3;

    // status codes on the result
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_ROW = 2'd1;
    localparam logic [1:0] ST_BAD_COL = 2'd2;

    localparam logic [5:0] MAX_COLUMN = 6'd39;
    localparam logic [7:0] CLEAR_CODE = 8'h01;
    localparam logic       DDRAM_FLAG = 1'b1;
    localparam logic [3:0] BYTE_WAIT  = 4'd2;
    localparam logic       RS_INSTR   = 1'b0;
    localparam logic       RS_DATA    = 1'b1;

    // last step of the init sequence (14 nibbles)
    localparam logic [3:0] INIT_LAST  = 4'd13;

    typedef enum logic [1:0] {
        OP_INIT,
        OP_BYTE,
        OP_ERR
    } t_op_kind;

    // classified request handed from front to back
    typedef struct packed {
        t_op_kind   kind;
        logic       rs;
        logic [7:0] byte_val;
        logic [1:0] status;
    } t_op;

    typedef struct packed {
        logic [3:0] nibble;
        logic [3:0] wait_ms;
    } t_nib;

    // init sequence: wake-up nibbles, then 0x28 0x08 0x01 0x06 0x0F high first
    function automatic t_nib init_entry(input logic [3:0] step);
        t_nib e;
        case (step)
            4'd0:    e = '{nibble: 4'h3, wait_ms: 4'd15};
            4'd1:    e = '{nibble: 4'h3, wait_ms: 4'd5};
            4'd2:    e = '{nibble: 4'h3, wait_ms: 4'd1};
            4'd3:    e = '{nibble: 4'h2, wait_ms: 4'd0};
            4'd4:    e = '{nibble: 4'h2, wait_ms: BYTE_WAIT};
            4'd5:    e = '{nibble: 4'h8, wait_ms: 4'd0};
            4'd6:    e = '{nibble: 4'h0, wait_ms: BYTE_WAIT};
            4'd7:    e = '{nibble: 4'h8, wait_ms: 4'd0};
            4'd8:    e = '{nibble: 4'h0, wait_ms: BYTE_WAIT};
            4'd9:    e = '{nibble: 4'h1, wait_ms: 4'd0};
            4'd10:   e = '{nibble: 4'h0, wait_ms: BYTE_WAIT};
            4'd11:   e = '{nibble: 4'h6, wait_ms: 4'd0};
            4'd12:   e = '{nibble: 4'h0, wait_ms: BYTE_WAIT};
            4'd13:   e = '{nibble: 4'hF, wait_ms: 4'd0};
            default: e = '{nibble: 4'h0, wait_ms: 4'd0};
        endcase
        return e;
    endfunction

endpackage

[rtl/lcdne_front.sv]
module lcdne_front (
    input  logic [1:0]    i_command,
    input  logic [1:0]    i_row,
    input  logic [5:0]    i_column,
    input  logic [7:0]    i_char_code,
    output lcdne_pkg::t_op o_op
);
    import lcdne_pkg::*;

    // classify the request into init, one byte, or an error result
    always_comb begin
        o_op = '{kind: OP_BYTE, rs: RS_INSTR, byte_val: 8'h00, status: ST_OK};
        case (i_command)
            CMD_INIT: begin
                o_op.kind = OP_INIT;
            end
            CMD_LOCATE: begin
                if (i_row > 2'd1) begin
                    o_op.kind   = OP_ERR;
                    o_op.status = ST_BAD_ROW;
                end else if (i_column > MAX_COLUMN) begin
                    o_op.kind   = OP_ERR;
                    o_op.status = ST_BAD_COL;
                end else begin
                    // column < 0x40, so base add is a plain bit insert
                    o_op.byte_val = {DDRAM_FLAG, i_row[0], i_column};
                end
            end
            CMD_CLEAR: begin
                o_op.byte_val = CLEAR_CODE;
            end
            CMD_WRITE: begin
                o_op.rs       = RS_DATA;
                o_op.byte_val = i_char_code;
            end
            default: begin
                o_op.kind = OP_ERR;
            end
        endcase
    end

endmodule

[rtl/lcdne_queue.sv]
module lcdne_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  lcdne_pkg::t_op i_wr_op,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output lcdne_pkg::t_op o_rd_op
);
    import lcdne_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rd_op = r_mem[r_rd_ptr];

    // pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (i_rd && !i_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_op;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full && !i_rd))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_valid)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

[rtl/lcdne_back.sv]
module lcdne_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op_valid,
    input  lcdne_pkg::t_op i_op,
    output logic           o_op_done,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_reg_select,
    output logic [3:0]     o_nibble,
    output logic [3:0]     o_wait_ms,
    output logic [1:0]     o_status,
    output logic           o_last
);
    import lcdne_pkg::*;

    logic       r_valid;
    logic [3:0] r_step, n_step;
    logic       r_rs, n_rs;
    logic [3:0] r_nibble, n_nibble;
    logic [3:0] r_wait, n_wait;
    logic [1:0] r_status, n_status;
    logic       r_last, n_last;
    logic       w_adv;
    t_nib       w_init;

    // output register takes a new nibble when empty or being drained
    assign w_adv     = i_op_valid && (!r_valid || i_pop);
    assign w_init    = init_entry(r_step);
    assign o_op_done = w_adv && n_last;

    // nibble for the current step of the head request
    always_comb begin
        n_rs     = RS_INSTR;
        n_nibble = 4'h0;
        n_wait   = 4'd0;
        n_status = ST_OK;
        n_last   = 1'b1;
        case (i_op.kind)
            OP_INIT: begin
                n_nibble = w_init.nibble;
                n_wait   = w_init.wait_ms;
                n_last   = (r_step == INIT_LAST);
            end
            OP_BYTE: begin
                n_rs = i_op.rs;
                if (r_step == 4'd0) begin
                    n_nibble = i_op.byte_val[7:4];
                    n_wait   = BYTE_WAIT;
                    n_last   = 1'b0;
                end else begin
                    n_nibble = i_op.byte_val[3:0];
                end
            end
            OP_ERR: begin
                n_status = i_op.status;
            end
            default: begin
                n_status = i_op.status;
            end
        endcase
        n_step = n_last ? 4'd0 : r_step + 4'd1;
    end

    // step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 4'd0;
        end else begin
            if (w_adv) begin
                r_valid <= 1'b1;
                r_step  <= n_step;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rs     <= n_rs;
            r_nibble <= n_nibble;
            r_wait   <= n_wait;
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

    assign o_empty      = !r_valid;
    assign o_reg_select = r_rs;
    assign o_nibble     = r_nibble;
    assign o_wait_ms    = r_wait;
    assign o_status     = r_status;
    assign o_last       = r_last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= INIT_LAST)
        else $error("step counter past init sequence");

    a_byte_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op_valid && i_op.kind != OP_INIT) |-> (r_step <= 4'd1))
        else $error("byte request beyond two nibbles");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != ST_OK) |-> (r_last && r_nibble == 4'h0
            && r_wait == 4'd0))
        else $error("error result not a lone empty result");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_nibble) && $stable(r_last)))
        else $error("result changed while stalled");

endmodule

[rtl/char_lcd_nibble_command_encoder_core.sv]
// Character LCD 4-bit request encoder.
// Input side is a queue write port: present command, row, column and
// char_code with push; the request is taken on a clock edge where push is
// high and full is low. Result side is a queue read port: while empty is
// low the oldest nibble (reg_select, nibble, wait_ms, status, last) is on
// the outputs, and pop takes it. last marks the final nibble of a request.
// Init gives 14 nibbles, locate/clear/write give 2, a bad locate gives one
// error result. The first result of a request passes through the queue and
// then the result register when the back end is idle.
// The back end sequencer emits one nibble per cycle while pop drains the
// result register; a small request queue between front and back lets new
// requests be taken while earlier nibbles are still going out.
// When pop stays low the result register holds, the queue fills and full
// rises. Reset empties the queue and the result register; no clearing pass.
module char_lcd_nibble_command_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_command,
    input  logic [1:0] i_row,
    input  logic [5:0] i_column,
    input  logic [7:0] i_char_code,
    output logic       empty,
    input  logic       pop,
    output logic       o_reg_select,
    output logic [3:0] o_nibble,
    output logic [3:0] o_wait_ms,
    output logic [1:0] o_status,
    output logic       o_last
);
    import lcdne_pkg::*;

    t_op  w_front_op;
    t_op  w_head_op;
    logic w_head_valid;
    logic w_head_done;
    logic w_push_ok;

    assign w_push_ok = push && !full;

    lcdne_front u_front (
        .i_command   (i_command),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_char_code (i_char_code),
        .o_op        (w_front_op)
    );

    lcdne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_push_ok),
        .i_wr_op (w_front_op),
        .o_full  (full),
        .i_rd    (w_head_done),
        .o_valid (w_head_valid),
        .o_rd_op (w_head_op)
    );

    lcdne_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (w_head_valid),
        .i_op         (w_head_op),
        .o_op_done    (w_head_done),
        .i_pop        (pop && !empty),
        .o_empty      (empty),
        .o_reg_select (o_reg_select),
        .o_nibble     (o_nibble),
        .o_wait_ms    (o_wait_ms),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule
